/* rtl/core/sctt_pkg.sv */
package sctt_pkg;

  localparam int unsigned MAX_TERMS = 32;
  localparam int unsigned K_W = $clog2(MAX_TERMS + 1);

  localparam logic [1:0] KIND_SIN = 2'd0;
  localparam logic [1:0] KIND_COS = 2'd1;

  localparam logic signed [32:0] TWO_PI_Q24 = 33'sd105414357;
  localparam logic [63:0] ONE_Q52 = 64'h0010_0000_0000_0000;
  localparam logic [63:0] SAT64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
  localparam logic [19:0] THR_RESET = 20'd107;

  // restoring divider request / response
  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [63:0]  den;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] quo;
  } div_rsp_t;

  // 32x32 multiplier operands
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

/* rtl/core/sctt_div.sv */
module sctt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sctt_pkg::div_req_t req,
  output sctt_pkg::div_rsp_t rsp
);

  logic [127:0] num_r, num_nxt;
  logic [63:0]  den_r, den_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [64:0]  sh;

  // one quotient bit per cycle; quotient shifts into num
  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r, num_r[127]};
    if (req.start) begin
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh[64] || (sh[63:0] >= den_r)) begin
        rem_nxt = sh[63:0] - den_r;
        num_nxt = {num_r[126:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        num_nxt = {num_r[126:0], 1'b0};
      end
      cnt_nxt = cnt_r + 8'd1;
      if (cnt_r == 8'd127) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule

/* rtl/core/sctt_mul.sv */
module sctt_mul (
  input  logic               clk,
  input  sctt_pkg::mul_req_t req,
  output logic [63:0]        prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

  assign prod = prod_r;

endmodule

/* rtl/core/sine_cosine_tangent_taylor_unit.sv */
// Sine / cosine / tangent by Taylor series, fixed point.
// Input stream: in_tdata = {angle (signed Q7.24)}, in_tuser = kind
// (0 sine, 1 cosine, 2 or 3 tangent). Output stream: out_tdata = value
// (signed Q17.30, 48 bits), out_tuser = overflow flag.
// One transaction in flight at a time: in_tready is high only while the
// unit is idle. Latency depends on angle and term_threshold: range folding
// steps the angle by 2pi until it is in range, x^2 takes four 32x32 partial
// products on the shared multiplier, and every series term costs one term
// check, four partial products and a restoring division of 128 quotient
// bits. A sine or cosine series runs at most 32 terms; tangent runs both
// series and one more division.
// The division unit, one quotient bit a cycle, sets the pace.
// The result is held in an output register until out_tready; the next
// input is taken once the result has been taken.
// APB register 0 (addr 0): term_threshold, 20 bits, units 2^-30, reset 107.
// Synchronous active-low reset returns the sequencer to idle, drops
// out_tvalid and restores term_threshold.
module sine_cosine_tangent_taylor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] angle
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [47:0] value
  output logic        out_tuser,  // [0] overflow
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;
  localparam logic [3:0] S_X2    = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_TMUL  = 4'd4;
  localparam logic [3:0] S_TDIV  = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_TANQ  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]  st_r, st_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic signed [32:0] ang_in_r, ang_in_nxt;
  logic signed [32:0] a_r, a_nxt;
  logic        cos_r, cos_nxt;       // current series is cosine
  logic [63:0] x2_r, x2_nxt;
  logic [63:0] term_r, term_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [63:0] sin_r, sin_nxt;
  logic [sctt_pkg::K_W-1:0] k_r, k_nxt;
  logic [2:0]  ph_r, ph_nxt;         // partial product phase
  logic [127:0] acc_r, acc_nxt;
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic        neg_r, neg_nxt;
  logic [19:0] thr_r;
  logic [47:0] val_r, val_nxt;
  logic        ovf_r, ovf_nxt;

  sctt_pkg::mul_req_t mreq;
  logic [63:0]        mprod;
  sctt_pkg::div_req_t dreq;
  sctt_pkg::div_rsp_t drsp;

  sctt_mul u_mul (.clk(clk), .req(mreq), .prod(mprod));
  sctt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // APB
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {12'd0, thr_r};
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= sctt_pkg::THR_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) thr_r <= cfg_pwdata[19:0];
  end

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  logic [63:0] thr52;
  logic [63:0] tmag;
  logic [2*sctt_pkg::K_W+1:0] k2;
  logic [2*sctt_pkg::K_W+1:0] dprod;
  logic [63:0] dval;
  logic [127:0] pp_sh;
  logic [127:0] acc_sum;
  logic [127:0] addv;
  logic [127:0] sh52;
  logic [63:0] qsat;
  logic [63:0] fin_src;
  logic [41:0] fin_hi;
  logic [63:0] fin_mag;
  logic [41:0] fin_q;
  logic [63:0] cmag, smag;
  logic tneg;
  logic [47:0] tlim;

  assign thr52 = {22'd0, thr_r, 22'd0};
  assign tmag  = mag64(term_r);
  assign k2    = {{(sctt_pkg::K_W + 1){1'b0}}, k_r, 1'b0};
  assign dprod = cos_r ? k2 * (k2 - {{(2 * sctt_pkg::K_W + 1){1'b0}}, 1'b1})
                       : k2 * (k2 + {{(2 * sctt_pkg::K_W + 1){1'b0}}, 1'b1});
  assign dval  = {{(64 - 2 * sctt_pkg::K_W - 2){1'b0}}, dprod};
  assign acc_sum = acc_r + pp_sh;
  // floor of the negated product: bias by 2^52-1 before the shift
  assign addv  = acc_sum + (neg_r ? {64'd0, sctt_pkg::ONE_Q52 - 64'd1} : 128'd0);
  assign sh52  = {52'd0, addv[127:52]};
  assign qsat  = (drsp.quo[127:63] != '0) ? sctt_pkg::SAT64 : drsp.quo[63:0];
  assign fin_src = sum_r;
  assign fin_mag = mag64(fin_src);
  assign fin_q   = fin_mag[63:22] + {41'd0, fin_mag[21:0] != 22'd0};
  assign fin_hi  = fin_src[63] ? (42'd0 - fin_q) : fin_src[63:22];
  assign cmag  = mag64(sum_r);
  assign smag  = mag64(sin_r);
  assign tneg  = sin_r[63] != sum_r[63];
  assign tlim  = tneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;

  // partial product select: phase picks the 32-bit halves
  always_comb begin
    case (ph_r[1:0])
      2'd0:    mreq = '{a: ma_r[31:0],  b: mb_r[31:0]};
      2'd1:    mreq = '{a: ma_r[31:0],  b: mb_r[63:32]};
      2'd2:    mreq = '{a: ma_r[63:32], b: mb_r[31:0]};
      default: mreq = '{a: ma_r[63:32], b: mb_r[63:32]};
    endcase
  end

  always_comb begin
    case (ph_r[1:0] - 2'd1)
      2'd0:    pp_sh = {64'd0, mprod};
      2'd1:    pp_sh = {32'd0, mprod, 32'd0};
      2'd2:    pp_sh = {32'd0, mprod, 32'd0};
      default: pp_sh = {mprod, 64'd0};
    endcase
  end

  always_comb begin
    st_nxt = st_r; kind_nxt = kind_r; ang_in_nxt = ang_in_r; a_nxt = a_r;
    cos_nxt = cos_r; x2_nxt = x2_r; term_nxt = term_r; sum_nxt = sum_r;
    sin_nxt = sin_r; k_nxt = k_r; ph_nxt = ph_r; acc_nxt = acc_r;
    ma_nxt = ma_r; mb_nxt = mb_r; neg_nxt = neg_r; val_nxt = val_r;
    ovf_nxt = ovf_r;
    dreq = '{start: 1'b0, num: '0, den: dval};
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = in_tuser;
          ang_in_nxt = {in_tdata[31], in_tdata};
          ovf_nxt    = 1'b0;
          cos_nxt    = (in_tuser == sctt_pkg::KIND_COS);
          a_nxt      = (in_tuser == sctt_pkg::KIND_COS && in_tdata[31])
                       ? -{in_tdata[31], in_tdata} : {in_tdata[31], in_tdata};
          st_nxt     = S_RED;
        end
      end
      S_RED: begin
        if (a_r > sctt_pkg::TWO_PI_Q24) a_nxt = a_r - sctt_pkg::TWO_PI_Q24;
        else if (!cos_r && a_r < -sctt_pkg::TWO_PI_Q24)
          a_nxt = a_r + sctt_pkg::TWO_PI_Q24;
        else begin
          term_nxt = {{3{a_r[32]}}, a_r[32:0], 28'd0};
          ma_nxt   = mag64({{3{a_r[32]}}, a_r[32:0], 28'd0});
          mb_nxt   = mag64({{3{a_r[32]}}, a_r[32:0], 28'd0});
          neg_nxt  = 1'b0;
          acc_nxt  = '0;
          ph_nxt   = '0;
          st_nxt   = S_X2;
        end
      end
      S_X2, S_TMUL: begin
        // 4 partial products, one result per cycle, each in the cycle after its issue
        if (ph_r != 3'd0) acc_nxt = acc_sum;
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd4) begin
          ph_nxt = '0;
          if (st_r == S_X2) begin
            x2_nxt  = acc_sum[115:52];
            if (cos_r) term_nxt = sctt_pkg::ONE_Q52;
            sum_nxt = '0;
            k_nxt   = '0;
            st_nxt  = S_CHK;
          end else begin
            st_nxt  = S_TDIV;
            dreq    = '{start: 1'b1, num: sh52, den: dval};
          end
        end
      end
      S_CHK: begin
        if (k_r < sctt_pkg::K_W'(sctt_pkg::MAX_TERMS) && tmag > thr52) begin
          sum_nxt = sum_r + term_r;
          k_nxt   = k_r + sctt_pkg::K_W'(1);
          neg_nxt = !term_r[63] && term_r != 64'd0;
          ma_nxt  = tmag;
          mb_nxt  = x2_r;
          acc_nxt = '0;
          ph_nxt  = '0;
          st_nxt  = S_TMUL;
        end else st_nxt = S_FIN;
      end
      S_TDIV: begin
        if (drsp.done) begin
          term_nxt = neg_r ? (64'd0 - qsat) : qsat;
          st_nxt   = S_CHK;
        end
      end
      S_FIN: begin
        if (kind_r == sctt_pkg::KIND_SIN || kind_r == sctt_pkg::KIND_COS) begin
          // 42-bit Q11.30 from 64-bit fits in 48-bit Q17.30 after sign extend
          val_nxt = {{6{fin_hi[41]}}, fin_hi};
          st_nxt  = S_OUT;
        end else if (!cos_r) begin
          sin_nxt = sum_r;
          cos_nxt = 1'b1;
          a_nxt   = ang_in_r[32] ? -ang_in_r : ang_in_r;
          st_nxt  = S_RED;
        end else if (sum_r == 64'd0) begin
          ovf_nxt = 1'b1;
          val_nxt = sin_r[63] ? sctt_pkg::MIN48 : sctt_pkg::MAX48;
          st_nxt  = S_OUT;
        end else begin
          dreq   = '{start: 1'b1, num: {34'd0, smag, 30'd0}, den: cmag};
          st_nxt = S_TANQ;
        end
      end
      S_TANQ: begin
        if (drsp.done) begin
          if (drsp.quo[127:48] != '0 || drsp.quo[47:0] > tlim) begin
            ovf_nxt = 1'b1;
            val_nxt = tneg ? sctt_pkg::MIN48 : sctt_pkg::MAX48;
          end else val_nxt = tneg ? (48'd0 - drsp.quo[47:0]) : drsp.quo[47:0];
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    kind_r <= kind_nxt; ang_in_r <= ang_in_nxt; a_r <= a_nxt; cos_r <= cos_nxt;
    x2_r <= x2_nxt; term_r <= term_nxt; sum_r <= sum_nxt; sin_r <= sin_nxt;
    k_r <= k_nxt; ph_r <= ph_nxt; acc_r <= acc_nxt; ma_r <= ma_nxt; mb_r <= mb_nxt;
    neg_r <= neg_nxt; val_r <= val_nxt; ovf_r <= ovf_nxt;
  end

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = val_r;
  assign out_tuser = ovf_r;

endmodule
